// ===== hw/rtl/skb_pkg.sv =====
// ----------------------------------------------------------------------------
// skb_pkg: shared types and constants for the scancode key buffer
// Command codes, scancode constants and the command queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package skb_pkg;

  // Default sizes
  localparam int RING_SLOTS_DEF  = 16;
  localparam int MAP_ENTRIES_DEF = 128;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input modes
  localparam logic [1:0] MODE_SCAN  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_MAPWR = 2'd3;

  // Set-1 scancodes of the modifier keys (low seven bits)
  localparam logic [6:0] SC_LSHIFT = 7'h2a;
  localparam logic [6:0] SC_LCTRL  = 7'h1d;
  localparam logic [6:0] SC_LALT   = 7'h38;
  localparam int         SC_REL_BIT = 7;

  // Modifier bit positions
  localparam int MOD_SHIFT = 0;
  localparam int MOD_CTRL  = 1;
  localparam int MOD_ALT   = 2;

  // Key map levels
  localparam logic [1:0] LVL_NORMAL  = 2'd0;
  localparam logic [1:0] LVL_SHIFTED = 2'd1;
  localparam logic [1:0] LVL_CTRL    = 2'd2;
  localparam logic [1:0] LVL_ALT     = 2'd3;

  // Classified commands
  typedef enum logic [2:0] {
    OP_NOP,
    OP_KEY,
    OP_POP,
    OP_PEEK,
    OP_MAPWR
  } skb_op_t;

  // One command handed from front to back
  typedef struct packed {
    skb_op_t     op;
    logic [6:0]  row;
    logic [1:0]  level;
    logic [15:0] value;
    logic [2:0]  mods;
  } skb_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skb_front.sv =====
// ----------------------------------------------------------------------------
// skb_front: command intake and classification
// Accepts items, tracks the modifier keys and queues one command per item.
// ----------------------------------------------------------------------------
`default_nettype none

module skb_front
  import skb_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_scancode,
  input  wire logic [6:0]  in_map_index,
  input  wire logic [1:0]  in_map_level,
  input  wire logic [15:0] in_map_value,
  input  wire logic        q_full,
  output logic             q_push,
  output skb_cmd_t         q_data
);

  logic [2:0] mods_r, mods_nxt;
  logic       accept;
  logic       is_rel;
  logic [6:0] code;
  logic       sc_in_map;
  logic       idx_in_map;
  logic       is_mod;
  logic [2:0] mod_mask;

  assign busy   = q_full;
  assign accept = start && !q_full;
  assign q_push = accept;

  assign code       = in_scancode[6:0];
  assign is_rel     = in_scancode[SC_REL_BIT];
  assign sc_in_map  = ({1'b0, in_scancode} < 9'(MAP_ENTRIES));
  assign idx_in_map = ({1'b0, in_map_index} < 8'(MAP_ENTRIES));

  // Decode the modifier key
  always_comb begin
    mod_mask = 3'b000;
    priority if (code == SC_LSHIFT) begin
      mod_mask[MOD_SHIFT] = 1'b1;
    end else if (code == SC_LCTRL) begin
      mod_mask[MOD_CTRL] = 1'b1;
    end else if (code == SC_LALT) begin
      mod_mask[MOD_ALT] = 1'b1;
    end else begin
      mod_mask = 3'b000;
    end
  end
  assign is_mod = (mod_mask != 3'b000);

  // Classify the item and update the modifiers
  always_comb begin
    mods_nxt       = mods_r;
    q_data.op      = OP_NOP;
    q_data.row     = code;
    q_data.level   = in_map_level;
    q_data.value   = in_map_value;
    unique case (in_mode)
      MODE_SCAN: begin
        if (in_scancode != 8'd0) begin
          if (is_mod) begin
            mods_nxt = is_rel ? (mods_r & ~mod_mask) : (mods_r | mod_mask);
          end else if (!is_rel && sc_in_map) begin
            q_data.op = OP_KEY;
          end
        end
      end
      MODE_POP:  q_data.op = OP_POP;
      MODE_PEEK: q_data.op = OP_PEEK;
      MODE_MAPWR: begin
        q_data.row = in_map_index;
        if (idx_in_map) begin
          q_data.op = OP_MAPWR;
        end
      end
      default: q_data.op = OP_NOP;
    endcase
    q_data.mods = mods_nxt;
  end

  // Hold the modifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= 3'b000;
    end else if (accept) begin
      mods_r <= mods_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/skb_queue.sv =====
// ----------------------------------------------------------------------------
// skb_queue: short command queue
// Decouples the intake side from the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module skb_queue
  import skb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire skb_cmd_t push_data,
  input  wire logic     pop,
  output skb_cmd_t      pop_data,
  output logic          full,
  output logic          empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  skb_cmd_t        slots_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slots_r[rd_r];

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/skb_back.sv =====
// ----------------------------------------------------------------------------
// skb_back: command execution
// Holds the key map and the key ring, runs each command in a fetch and an execute state.
// ----------------------------------------------------------------------------
`default_nettype none

module skb_back
  import skb_pkg::*;
#(
  parameter int RING_SLOTS  = RING_SLOTS_DEF,
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire skb_cmd_t q_data,
  output logic          q_pop,
  output logic          out_strobe,
  output logic [15:0]   out_head_key,
  output logic          out_key_available,
  output logic [3:0]    out_shift_flags,
  output logic          out_full_mark,
  output logic          out_nonempty_mark,
  output logic          out_key_dropped
);

  localparam int RING_AW = $clog2(RING_SLOTS);
  localparam int MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  typedef enum logic {
    ST_FETCH,
    ST_EXEC
  } state_t;

  state_t state_r;

  // Key map: one row per scancode, one lane per level
  logic [3:0][15:0] map_mem [MAP_ENTRIES];
  logic [3:0][15:0] map_rd_r;
  // Key ring
  logic [15:0]      ring_mem [RING_SLOTS];
  logic [15:0]      ring_rd_r;

  skb_cmd_t         cmd_r;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [RING_AW-1:0] tail_r, tail_nxt;
  logic             full_r, full_nxt;
  logic             nonempty_r, nonempty_nxt;

  logic [RING_AW-1:0] tail_inc, head_inc;
  logic [15:0]      key_sel;
  logic             avail;
  logic             ring_we;
  logic [15:0]      head_key;
  logic             dropped;

  assign q_pop = (state_r == ST_FETCH) && !q_empty;

  // Read map row and ring head
  always_ff @(posedge clk) begin
    map_rd_r  <= map_mem[q_data.row[MAP_AW-1:0]];
    ring_rd_r <= ring_mem[head_r];
  end

  // Write one map lane
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC && cmd_r.op == OP_MAPWR) begin
      map_mem[cmd_r.row[MAP_AW-1:0]][cmd_r.level] <= cmd_r.value;
    end
  end

  // Write the ring tail
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[tail_r] <= key_sel;
    end
  end

  assign tail_inc = (tail_r == RING_AW'(RING_SLOTS - 1)) ? '0 : tail_r + RING_AW'(1);
  assign head_inc = (head_r == RING_AW'(RING_SLOTS - 1)) ? '0 : head_r + RING_AW'(1);
  assign avail    = (head_r != tail_r);

  // Pick the key variant by modifier priority
  always_comb begin
    priority if (cmd_r.mods[MOD_SHIFT] && map_rd_r[LVL_SHIFTED] != 16'd0) begin
      key_sel = map_rd_r[LVL_SHIFTED];
    end else if (cmd_r.mods[MOD_CTRL] && map_rd_r[LVL_CTRL] != 16'd0) begin
      key_sel = map_rd_r[LVL_CTRL];
    end else if (cmd_r.mods[MOD_ALT] && map_rd_r[LVL_ALT] != 16'd0) begin
      key_sel = map_rd_r[LVL_ALT];
    end else begin
      key_sel = map_rd_r[LVL_NORMAL];
    end
  end

  // Execute the command
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    full_nxt     = full_r;
    nonempty_nxt = nonempty_r;
    ring_we      = 1'b0;
    head_key     = 16'd0;
    dropped      = 1'b0;
    if (state_r == ST_EXEC) begin
      unique case (cmd_r.op)
        OP_KEY: begin
          if (key_sel != 16'd0) begin
            if (tail_inc == head_r) begin
              full_nxt = 1'b1;
              dropped  = 1'b1;
            end else begin
              full_nxt     = 1'b0;
              nonempty_nxt = 1'b1;
              ring_we      = 1'b1;
              tail_nxt     = tail_inc;
            end
          end
        end
        OP_POP: begin
          if (avail) begin
            head_key = ring_rd_r;
            head_nxt = head_inc;
            if (head_inc == tail_r) begin
              nonempty_nxt = 1'b0;
            end
          end
        end
        OP_PEEK: begin
          if (avail) begin
            head_key = ring_rd_r;
          end
        end
        OP_NOP, OP_MAPWR: begin
          head_key = 16'd0;
        end
        default: head_key = 16'd0;
      endcase
    end
  end

  // Hold state, pointers, flags and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FETCH;
      head_r     <= '0;
      tail_r     <= '0;
      full_r     <= 1'b0;
      nonempty_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      full_r     <= full_nxt;
      nonempty_r <= nonempty_nxt;
      out_strobe <= (state_r == ST_EXEC);
      unique case (state_r)
        ST_FETCH: begin
          if (!q_empty) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: state_r <= ST_FETCH;
        default: state_r <= ST_FETCH;
      endcase
    end
  end

  // Latch command and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    if (state_r == ST_EXEC) begin
      out_head_key      <= head_key;
      out_key_available <= avail;
      out_shift_flags   <= {cmd_r.mods, 1'b0};
      out_full_mark     <= full_nxt;
      out_nonempty_mark <= nonempty_nxt;
      out_key_dropped   <= dropped;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_key_buffer.sv =====
// ----------------------------------------------------------------------------
// scancode_key_buffer: keyboard type-ahead buffer fed by set-1 scancodes
//
//   channel  ports                          handshake
//   input    in_mode .. in_map_value        start high, busy low at clock edge
//   result   out_head_key .. out_key_dropped out_strobe high for one cycle
//
// In the execution side each item is first fetched, which reads the key map
// row and the ring head, then executed, which updates the ring and registers
// the result. A result passes the command queue, the fetch and execute
// states and the result register before it is on the ports.
// busy rises while the two-entry command queue is full. Reset is
// synchronous; the key map and ring are not cleared and must be written
// before use. The receiver cannot stall; out_strobe marks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_key_buffer
  import skb_pkg::*;
#(
  parameter int RING_SLOTS  = RING_SLOTS_DEF,
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_scancode,
  input  wire logic [6:0]  in_map_index,
  input  wire logic [1:0]  in_map_level,
  input  wire logic [15:0] in_map_value,
  output logic             out_strobe,
  output logic [15:0]      out_head_key,
  output logic             out_key_available,
  output logic [3:0]       out_shift_flags,
  output logic             out_full_mark,
  output logic             out_nonempty_mark,
  output logic             out_key_dropped
);

  logic     q_push, q_pop, q_full, q_empty;
  skb_cmd_t push_cmd, pop_cmd;

  // Intake and classification
  skb_front #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_scancode  (in_scancode),
    .in_map_index (in_map_index),
    .in_map_level (in_map_level),
    .in_map_value (in_map_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_cmd)
  );

  // Command queue
  skb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Execution
  skb_back #(
    .RING_SLOTS (RING_SLOTS),
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (pop_cmd),
    .q_pop             (q_pop),
    .out_strobe        (out_strobe),
    .out_head_key      (out_head_key),
    .out_key_available (out_key_available),
    .out_shift_flags   (out_shift_flags),
    .out_full_mark     (out_full_mark),
    .out_nonempty_mark (out_nonempty_mark),
    .out_key_dropped   (out_key_dropped)
  );

endmodule

`default_nettype wire
